### rtl/axis_angle_to_rotation_matrix_defines.svh
// Assertion macros shared by the axis-angle to rotation matrix RTL.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication
`define AARM_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("aarm: implication check failed");

// next-cycle implication
`define AARM_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("aarm: next-cycle check failed");

`endif

### rtl/aarm_pkg.sv
// Constants, types and the arctangent table for the axis-angle to matrix pipeline.
// No dependencies.
package aarm_pkg;

    localparam int TURN_UNITS        = 23040;
    localparam int QUARTER_UNITS     = 11520;
    localparam int Z_INT_MUL         = 146408;   // floor(pi*2^30 / 23040)
    localparam int Z_FRAC_MUL        = 19106;    // pi*2^30 mod 23040
    localparam int RECIP45           = 745655;   // ceil(2^25 / 45)
    localparam int INV_GAIN_Q30      = 652032874;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int CW = 34;   // cordic x/y width
    localparam int ZW = 33;   // cordic angle width
    localparam int QW = 27;   // quaternion width, Q24
    localparam int PW = 56;   // product / sum width, Q48

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } axis_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/axis_angle_to_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix, fully pipelined.
// Depends on aarm_pkg and axis_angle_to_rotation_matrix_defines.svh.
//
// One request per cycle in, one matrix per cycle out while m_axis_tready is
// high. The stages are angle reduction, two multiply stages for the
// degree-to-radian scaling, the CORDIC seed, one CORDIC stage per iteration
// (CORDIC_STAGES, capped at 24), the quaternion multiply, the nine quaternion
// products and the rounding/saturation stage.
// Every stage has its own valid bit and its own load enable, so bubbles fill
// up on a stall and the input keeps taking requests until the pipe is full.
`include "axis_angle_to_rotation_matrix_defines.svh"

module axis_angle_to_rotation_matrix #(
    parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // axis_x, axis_y, axis_z, angle_deg
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);

    localparam int CW  = aarm_pkg::CW;
    localparam int ZW  = aarm_pkg::ZW;
    localparam int QW  = aarm_pkg::QW;
    localparam int PW  = aarm_pkg::PW;
    localparam int NST = (CORDIC_STAGES > aarm_pkg::ATAN_ENTRIES) ?
                         aarm_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam int SQ  = 4 + NST;   // quaternion stage
    localparam int SP  = 5 + NST;   // product stage
    localparam int SO  = 6 + NST;   // output stage
    localparam int NS  = 7 + NST;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = m_axis_tready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? s_axis_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // axis travels alongside up to the quaternion stage
    aarm_pkg::axis_t axis_reg [0:SQ-1];
    logic            neg_reg  [0:2];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            axis_reg[0] <= '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                             z: s_axis_tdata[47:32]};
        end
        for (int i = 1; i < SQ; i++)
        begin
            if (en[i])
            begin
                axis_reg[i] <= axis_reg[i-1];
            end
        end
    end

    // stage 0: reduce modulo one turn, fold into [-90, 90] degrees half angle
    logic signed [17:0] ang_s;
    logic signed [17:0] red_s;
    logic [14:0]        r_val;
    logic [13:0]        mag_next;
    logic               neg_next;
    logic [13:0]        mag_reg;

    always_comb
    begin
        ang_s = 18'($signed(s_axis_tdata[63:48]));
        if (ang_s < 0)
        begin
            red_s = ang_s + 18'sd23040;
            if (red_s < 0)
            begin
                red_s = red_s + 18'sd23040;
            end
        end
        else if (ang_s >= 18'sd23040)
        begin
            red_s = ang_s - 18'sd23040;
        end
        else
        begin
            red_s = ang_s;
        end
        r_val = red_s[14:0];
        if (r_val <= 15'(aarm_pkg::QUARTER_UNITS))
        begin
            mag_next = r_val[13:0];
            neg_next = 1'b0;
        end
        else
        begin
            mag_next = 14'(15'(aarm_pkg::TURN_UNITS) - r_val);
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg    <= mag_next;
            neg_reg[0] <= neg_next;
        end
        for (int i = 1; i < 3; i++)
        begin
            if (en[i])
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // stage 1: split the radian scale into integer and fractional parts of pi*2^30/23040
    logic [31:0] p1_reg [1:2];
    logic [28:0] p2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p1_reg[1] <= 32'(mag_reg) * 32'(aarm_pkg::Z_INT_MUL);
            p2_reg    <= 29'(mag_reg) * 29'(aarm_pkg::Z_FRAC_MUL);
        end
    end

    // stage 2: rounded divide by 23040 = 512 * 45 via reciprocal
    logic [18:0] t_val;
    logic [38:0] qp_reg;

    assign t_val = 19'((p2_reg + 29'(aarm_pkg::QUARTER_UNITS)) >> 9);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p1_reg[2] <= p1_reg[1];
            qp_reg    <= 39'(t_val) * 39'(aarm_pkg::RECIP45);
        end
    end

    // stage 3: angle in Q2.30 radians, CORDIC seed
    logic signed [CW-1:0] cx_reg [0:NST];
    logic signed [CW-1:0] cy_reg [0:NST];
    logic signed [ZW-1:0] cz_reg [0:NST];
    logic [31:0]          zmag;

    assign zmag = p1_reg[2] + 32'(qp_reg >> 25);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            cx_reg[0] <= CW'(aarm_pkg::INV_GAIN_Q30);
            cy_reg[0] <= '0;
            cz_reg[0] <= neg_reg[2] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
        end
    end

    // CORDIC, one iteration per stage
    for (genvar k = 0; k < NST; k++)
    begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] at;

        assign dx = cy_reg[k] >>> k;
        assign dy = cx_reg[k] >>> k;
        assign at = $signed({1'b0, aarm_pkg::atan_q30(5'(k))});

        always_ff @(posedge clk)
        begin
            if (en[4+k])
            begin
                if (!cz_reg[k][ZW-1])
                begin
                    cx_reg[k+1] <= cx_reg[k] - dx;
                    cy_reg[k+1] <= cy_reg[k] + dy;
                    cz_reg[k+1] <= cz_reg[k] - at;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] + dx;
                    cy_reg[k+1] <= cy_reg[k] - dy;
                    cz_reg[k+1] <= cz_reg[k] + at;
                end
            end
        end
    end

    // quaternion stage, Q24
    logic signed [QW-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [49:0]   mx, my, mz;
    logic signed [CW-1:0] wr;

    assign mx = $signed(axis_reg[SQ-1].x) * 50'(cy_reg[NST]) + 50'sd524288;
    assign my = $signed(axis_reg[SQ-1].y) * 50'(cy_reg[NST]) + 50'sd524288;
    assign mz = $signed(axis_reg[SQ-1].z) * 50'(cy_reg[NST]) + 50'sd524288;
    assign wr = (cx_reg[NST] + CW'(32)) >>> 6;

    always_ff @(posedge clk)
    begin
        if (en[SQ])
        begin
            qx_reg <= QW'(mx >>> 20);
            qy_reg <= QW'(my >>> 20);
            qz_reg <= QW'(mz >>> 20);
            qw_reg <= QW'(wr);
        end
    end

    // product stage, Q48
    logic signed [PW-1:0] xx_reg, xy_reg, xz_reg, yy_reg, yz_reg, zz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [QW:0]   x2, y2, z2;

    assign x2 = {qx_reg, 1'b0};
    assign y2 = {qy_reg, 1'b0};
    assign z2 = {qz_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en[SP])
        begin
            xx_reg <= PW'(qx_reg * x2);
            xy_reg <= PW'(qx_reg * y2);
            xz_reg <= PW'(qx_reg * z2);
            yy_reg <= PW'(qy_reg * y2);
            yz_reg <= PW'(qy_reg * z2);
            zz_reg <= PW'(qz_reg * z2);
            wx_reg <= PW'(qw_reg * x2);
            wy_reg <= PW'(qw_reg * y2);
            wz_reg <= PW'(qw_reg * z2);
        end
    end

    // output stage: sums, round to Q14, saturate
    function automatic logic [15:0] sat_q14(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        logic [15:0]          o;
        r = (v + (PW'(1) <<< 33)) >>> 34;
        if (r > PW'(32767))
        begin
            o = 16'h7fff;
        end
        else if (r < -PW'(32768))
        begin
            o = 16'h8000;
        end
        else
        begin
            o = r[15:0];
        end
        return o;
    endfunction

    localparam logic signed [PW-1:0] ONE_Q48 = PW'(1) <<< 48;

    logic [143:0] out_next;
    logic [143:0] out_reg;

    always_comb
    begin
        out_next[15:0]    = sat_q14(ONE_Q48 - (yy_reg + zz_reg));
        out_next[31:16]   = sat_q14(xy_reg - wz_reg);
        out_next[47:32]   = sat_q14(xz_reg + wy_reg);
        out_next[63:48]   = sat_q14(xy_reg + wz_reg);
        out_next[79:64]   = sat_q14(ONE_Q48 - (xx_reg + zz_reg));
        out_next[95:80]   = sat_q14(yz_reg - wx_reg);
        out_next[111:96]  = sat_q14(xz_reg - wy_reg);
        out_next[127:112] = sat_q14(yz_reg + wx_reg);
        out_next[143:128] = sat_q14(ONE_Q48 - (xx_reg + yy_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[SO])
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tdata = out_reg;

    `AARM_ASSERT_IMP(a_empty_out_ready, !m_axis_tvalid, s_axis_tready)
    `AARM_ASSERT_IMP(a_fold_range, vld_reg[0], mag_reg <= 14'(aarm_pkg::QUARTER_UNITS))
    `AARM_ASSERT_IMP(a_z_range, vld_reg[3],
                     (cz_reg[0] <= ZW'(1686629713)) && (cz_reg[0] >= -ZW'(1686629713)))
    `AARM_ASSERT_NXT(a_take, s_axis_tvalid && s_axis_tready, vld_reg[0])

endmodule
